// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the pending query table.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/pqt_pkg.sv =====
// Package of the pending query table: sizes, codes, the slot entry type.
// Used by the top level; depends on nothing.
package pqt_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int ID_W        = 16;
  localparam int CNT_W       = 4;

  localparam logic [SLOT_W:0]      SCAN_END        = (SLOT_W + 1)'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0]    LAST_SLOT       = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [RES_CNT_W-1:0] RES_LIMIT       = RES_CNT_W'(MAX_RESULTS);
  localparam logic [RES_CNT_W-1:0] RES_FINAL       = RES_CNT_W'(MAX_RESULTS - 1);
  localparam logic [CNT_W-1:0]     MIN_NAMES       = 4'd1;
  localparam logic [CNT_W-1:0]     MAX_NAMES       = 4'd8;
  localparam logic [CNT_W-1:0]     SEND_COUNT_MAX  = 4'd15;
  localparam logic [CNT_W-1:0]     SEND_COUNT_INIT = 4'd1;
  localparam logic [CNT_W-1:0]     MAX_SENDS_RESET = 4'd4;
  localparam logic [ID_W-1:0]      FIRST_QUERY_ID  = 16'd1;
  localparam logic [7:0]           MSG_TYPE_ANSWER = 8'd1;

  typedef enum logic [1:0] {
    OP_NEW  = 2'd0,
    OP_TICK = 2'd1,
    OP_RESP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_SENT     = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_CNT  = 3'd2,
    ST_RESEND   = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_ANSWERED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  query_id;
    logic [CNT_W-1:0] send_count;
    logic [CNT_W-1:0] name_count;
  } entry_t;

  function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

endpackage

// ===== sv/pqt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; takes width and depth as parameters.
module pqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pending_query_table_with_retry.sv =====
// Top level of the pending query table with retries.
// Depends on pqt_pkg, pqt_ram and assert_macros.svh.
//
// A new request is taken while busy stays low, and its single result
// appears on the following cycle. A timeout tick walks every slot through
// the slot RAM, one read per cycle with a registered read, and holds busy
// until the last slot is done. A response of the answer type walks the same
// way and stops at the first busy slot with a matching id, or after the last
// slot when none matches. A response of another type and an unknown operation
// finish at once with no result. Each result is shown for one cycle with
// result_valid high and cannot be held off, so the receiver must take every
// transfer as it comes. Slot occupancy is kept in flip-flops that reset
// clears, so no clearing pass follows reset.
`include "assert_macros.svh"

module pending_query_table_with_retry
  import pqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] response_id,
  input  logic [7:0]  message_type,
  input  logic [3:0]  name_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [15:0] query_id,
  output logic [3:0]  slot,
  output logic [3:0]  names_in_query,
  output logic        last
);

  state_t                 state, state_next;
  logic [SLOT_COUNT-1:0]  slot_busy, slot_busy_next;
  logic [ID_W-1:0]        next_query_id, next_query_id_next;
  logic [CNT_W-1:0]       max_sends;
  logic [SLOT_W:0]        scan_idx, scan_idx_next;
  logic                   pipe_valid, pipe_valid_next;
  logic [SLOT_W-1:0]      pipe_idx, pipe_idx_next;
  logic [RES_CNT_W-1:0]   result_cnt, result_cnt_next;
  logic [ID_W-1:0]        resp_id, resp_id_next;

  logic                   result_valid_next;
  logic [2:0]             status_next;
  logic [15:0]            query_id_next;
  logic [3:0]             slot_next;
  logic [3:0]             names_in_query_next;
  logic                   last_next;

  logic                   ram_we, ram_re;
  logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
  entry_t                 ram_wdata, ram_rdata;

  logic                   accept;
  logic                   names_ok;
  logic                   free_found;
  logic [SLOT_W-1:0]      first_free;
  logic                   higher_busy;
  logic                   new_full;
  logic                   new_sent;

  pqt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start && !busy;
  assign names_ok  = (name_count >= MIN_NAMES) && (name_count <= MAX_NAMES);
  assign higher_busy = |((slot_busy >> pipe_idx) >> 1);
  assign new_full  = accept && (operation == OP_NEW) && names_ok && !free_found;
  assign new_sent  = accept && (operation == OP_NEW) && names_ok && free_found;

  always_comb begin
    free_found = 1'b0;
    first_free = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_found = 1'b1;
        first_free = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_busy     <= '0;
      next_query_id <= FIRST_QUERY_ID;
      max_sends     <= MAX_SENDS_RESET;
      scan_idx      <= '0;
      pipe_valid    <= 1'b0;
      result_cnt    <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      slot_busy     <= slot_busy_next;
      next_query_id <= next_query_id_next;
      scan_idx      <= scan_idx_next;
      pipe_valid    <= pipe_valid_next;
      result_cnt    <= result_cnt_next;
      result_valid  <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        max_sends <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx       <= pipe_idx_next;
    resp_id        <= resp_id_next;
    status         <= status_next;
    query_id       <= query_id_next;
    slot           <= slot_next;
    names_in_query <= names_in_query_next;
    last           <= last_next;
  end

  always_comb begin
    state_next          = state;
    slot_busy_next      = slot_busy;
    next_query_id_next  = next_query_id;
    scan_idx_next       = scan_idx;
    pipe_valid_next     = pipe_valid;
    pipe_idx_next       = pipe_idx;
    result_cnt_next     = result_cnt;
    resp_id_next        = resp_id;
    result_valid_next   = 1'b0;
    status_next         = status;
    query_id_next       = query_id;
    slot_next           = slot;
    names_in_query_next = names_in_query;
    last_next           = last;
    ram_we              = 1'b0;
    ram_waddr           = pipe_idx;
    ram_wdata           = ram_rdata;
    ram_re              = 1'b0;
    ram_raddr           = scan_idx[SLOT_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_NEW: begin
              result_valid_next = 1'b1;
              last_next         = 1'b1;
              if (!names_ok) begin
                status_next         = ST_BAD_CNT;
                query_id_next       = '0;
                slot_next           = '0;
                names_in_query_next = '0;
              end else if (!free_found) begin
                status_next         = ST_FULL;
                query_id_next       = '0;
                slot_next           = '0;
                names_in_query_next = '0;
              end else begin
                ram_we                     = 1'b1;
                ram_waddr                  = first_free;
                ram_wdata.query_id         = next_query_id;
                ram_wdata.send_count       = SEND_COUNT_INIT;
                ram_wdata.name_count       = name_count;
                slot_busy_next[first_free] = 1'b1;
                status_next                = ST_SENT;
                query_id_next              = next_query_id;
                slot_next                  = slot_field(first_free);
                names_in_query_next        = name_count;
                next_query_id_next         = next_query_id + 1'b1;
              end
            end
            OP_TICK: begin
              state_next      = S_TICK;
              scan_idx_next   = '0;
              pipe_valid_next = 1'b0;
              result_cnt_next = '0;
            end
            OP_RESP: begin
              if (message_type == MSG_TYPE_ANSWER) begin
                state_next      = S_RESP;
                scan_idx_next   = '0;
                pipe_valid_next = 1'b0;
                resp_id_next    = response_id;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_TICK, S_RESP: begin
        if (scan_idx < SCAN_END) begin
          ram_re          = 1'b1;
          pipe_valid_next = 1'b1;
          pipe_idx_next   = scan_idx[SLOT_W-1:0];
          scan_idx_next   = scan_idx + 1'b1;
        end else begin
          pipe_valid_next = 1'b0;
        end

        if (pipe_valid) begin
          if (state == S_TICK) begin
            if (slot_busy[pipe_idx]) begin
              ram_we = 1'b1;
              if (ram_rdata.send_count >= max_sends) begin
                status_next              = ST_EXPIRED;
                slot_busy_next[pipe_idx] = 1'b0;
                ram_wdata.send_count     = '0;
              end else begin
                status_next = ST_RESEND;
                if (ram_rdata.send_count < SEND_COUNT_MAX) begin
                  ram_wdata.send_count = ram_rdata.send_count + 1'b1;
                end
              end
              if (result_cnt < RES_LIMIT) begin
                result_valid_next   = 1'b1;
                query_id_next       = ram_rdata.query_id;
                slot_next           = slot_field(pipe_idx);
                names_in_query_next = ram_rdata.name_count;
                last_next           = !higher_busy || (result_cnt == RES_FINAL);
                result_cnt_next     = result_cnt + 1'b1;
              end
            end
            if (pipe_idx == LAST_SLOT) begin
              state_next      = S_IDLE;
              pipe_valid_next = 1'b0;
            end
          end else begin
            if (slot_busy[pipe_idx] && (ram_rdata.query_id == resp_id)) begin
              result_valid_next        = 1'b1;
              status_next              = ST_ANSWERED;
              query_id_next            = ram_rdata.query_id;
              slot_next                = slot_field(pipe_idx);
              names_in_query_next      = ram_rdata.name_count;
              last_next                = 1'b1;
              slot_busy_next[pipe_idx] = 1'b0;
              state_next               = S_IDLE;
              pipe_valid_next          = 1'b0;
            end else if (pipe_idx == LAST_SLOT) begin
              state_next      = S_IDLE;
              pipe_valid_next = 1'b0;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A write-back never targets the slot being fetched in the same cycle.
  `ASSERT_IMPL(a_wb_no_overlap, clk, rst, pipe_valid && ram_we && ram_re, ram_raddr != pipe_idx)

  // A valid request that finds every slot taken reports a full table.
  `ASSERT_NEXT(a_full_report, clk, rst, new_full, result_valid && status == ST_FULL && last)

  // The id counter moves only after a request has been sent.
  `ASSERT_IMPL(a_id_step, clk, rst, $past(!rst) && !$stable(next_query_id), $past(new_sent))

endmodule
